FILE: rtl/ipap_pkg.sv
package ipap_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 10;
    localparam int STEPS_W  = 7;
    localparam int WRAP_W   = 16;
    localparam int DUTY_W   = 16;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 16;

    // Full-scale level and its Q40 reciprocal, exact for products below 2^28
    localparam logic [SAMPLE_W-1:0] FULL_LEVEL   = 12'd4095;
    localparam int                  PROD_W       = SAMPLE_W + WRAP_W;
    localparam int                  RECIP_W      = 29;
    localparam logic [RECIP_W-1:0]  RECIP_K      = 29'd268501009;
    localparam int                  RECIP_SHIFT  = 40;
    localparam int                  SCALED_W     = PROD_W + RECIP_W;

    // Register indexes
    localparam logic [CFG_AW-1:0] CFG_GAIN  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_STEPS = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_WRAP  = 2'd2;

    // Register reset values
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 10'd435;
    localparam logic [STEPS_W-1:0] STEPS_RST = 7'd1;
    localparam logic [WRAP_W-1:0]  WRAP_RST  = 16'd3048;

    localparam int MAX_STEPS_DEF = 64;

    // Queue between front and back
    localparam int QDEPTH = 2;

    // One sample pair handed to the step engine
    typedef struct packed {
        logic [SAMPLE_W-1:0] prev;
        logic [SAMPLE_W-1:0] cur;
    } t_pair;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_MUL,
        ST_RECIP,
        ST_EMIT
    } t_back_state;

endpackage

FILE: rtl/interpolating_pwm_audio_player.sv
// Path: with the step engine idle, a pair's first duty value passes the queue, the serial
// divide, the fix-up, both multiply stages and the emit state into the output register.
// Step engine: a sample that pairs with the previous one takes a serial divide, then two
// multiply stages and an emit that waits for the output per step; a clip start is not queued.
// A two-entry queue lets the front accept while the engine runs.
// Reset (synchronous, active low): registers return to gain 435, steps 1, wrap 3048,
// the stored level clears, the queue and output empty.
module interpolating_pwm_audio_player
    import ipap_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [11:0] sample, [15:12] zero
    input  logic              s_axis_tuser,   // [0] clip_start
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [15:0] duty
    output logic              m_axis_tlast,   // last step of a pair
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    logic [GAIN_W-1:0]  r_gain;
    logic [STEPS_W-1:0] r_steps;
    logic [WRAP_W-1:0]  r_wrap;
    logic               q_full;
    logic               q_push;
    t_pair              q_in;
    logic               q_pop;
    logic               q_valid;
    t_pair              q_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RST;
            r_steps <= STEPS_RST;
            r_wrap  <= WRAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GAIN:  r_gain  <= i_cfg_wdata[GAIN_W-1:0];
                CFG_STEPS: r_steps <= i_cfg_wdata[STEPS_W-1:0];
                CFG_WRAP:  r_wrap  <= i_cfg_wdata[WRAP_W-1:0];
                default: ;
            endcase
        end
    end

    ipap_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gain       (r_gain),
        .i_valid      (s_axis_tvalid),
        .i_sample     (s_axis_tdata[SAMPLE_W-1:0]),
        .i_clip_start (s_axis_tuser),
        .o_ready      (s_axis_tready),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_pair     (q_in)
    );

    ipap_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    ipap_back #(
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_steps   (r_steps),
        .i_wrap    (r_wrap),
        .i_q_valid (q_valid),
        .i_q_pair  (q_out),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_duty    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule

FILE: rtl/ipap_front.sv
module ipap_front
    import ipap_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [GAIN_W-1:0]   i_gain,
    input  logic                i_valid,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_clip_start,
    output logic                o_ready,
    input  logic                i_q_full,
    output logic                o_q_push,
    output t_pair               o_q_pair
);

    logic [SAMPLE_W-1:0]        r_prev;
    logic                       r_have;
    logic [SAMPLE_W+GAIN_W-1:0] gain_prod;
    logic [SAMPLE_W+GAIN_W-9:0] gain_shift;
    logic [SAMPLE_W-1:0]        cur;
    logic                       accept;
    logic                       pair;

    // Scale by the Q8 gain and clamp to full level
    assign gain_prod  = i_sample * i_gain;
    assign gain_shift = gain_prod[SAMPLE_W+GAIN_W-1:8];
    assign cur        = (gain_shift > {{(GAIN_W-8){1'b0}}, FULL_LEVEL}) ?
                        FULL_LEVEL : gain_shift[SAMPLE_W-1:0];

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign pair    = !i_clip_start && r_have;

    assign o_q_push      = accept && pair;
    assign o_q_pair.prev = r_prev;
    assign o_q_pair.cur  = cur;

    // Hold the previous scaled level for the next pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_have <= 1'b0;
        end else if (accept) begin
            r_prev <= cur;
            r_have <= 1'b1;
        end
    end

endmodule

FILE: rtl/ipap_fifo.sv
module ipap_fifo
    import ipap_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_pair o_data
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_pair         r_mem [QDEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/ipap_back.sv
module ipap_back
    import ipap_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [STEPS_W-1:0] i_steps,
    input  logic [WRAP_W-1:0]  i_wrap,
    input  logic               i_q_valid,
    input  t_pair              i_q_pair,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [DUTY_W-1:0]  o_duty,
    output logic               o_last
);

    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int IW = $clog2(SAMPLE_W);

    t_back_state           r_state;
    t_back_state           n_state;
    logic [SW-1:0]         r_s;
    logic [SW-1:0]         r_p;
    logic [SW-1:0]         r_rem;
    logic [SW-1:0]         r_dr;
    logic [SW-1:0]         r_r;
    logic [SAMPLE_W-1:0]   r_mag;
    logic                  r_neg;
    logic [IW-1:0]         r_iter;
    logic signed [SAMPLE_W:0] r_dq;
    logic [SAMPLE_W-1:0]   r_v;
    logic [PROD_W-1:0]     r_x;
    logic [SCALED_W-1:0]   r_prod;
    logic                  r_out_valid;
    logic [DUTY_W-1:0]     r_duty;
    logic                  r_last;

    logic [SW-1:0]         s_eff;
    logic [SW:0]           div_t;
    logic                  div_ge;
    logic [SW:0]           rsum;
    logic                  carry;
    logic signed [SAMPLE_W+1:0] v_sum;
    logic                  out_free;
    logic                  emit;
    logic                  is_last;

    // Clamp steps to 1..MAX_STEPS
    always_comb begin
        if (i_steps == '0) begin
            s_eff = SW'(1);
        end else if (i_steps > STEPS_W'(MAX_STEPS)) begin
            s_eff = SW'(MAX_STEPS);
        end else begin
            s_eff = SW'(i_steps);
        end
    end

    // Restoring divide step: one quotient bit per cycle
    assign div_t  = {r_rem, r_mag[SAMPLE_W-1]};
    assign div_ge = (div_t >= {1'b0, r_s});

    // Advance level by the quotient, carrying the remainder
    assign rsum  = {1'b0, r_r} + {1'b0, r_dr};
    assign carry = (rsum >= {1'b0, r_s});
    assign v_sum = $signed({2'b00, r_v}) + (SAMPLE_W+2)'(r_dq)
                 + $signed({{(SAMPLE_W+1){1'b0}}, carry});

    assign out_free = !r_out_valid || i_ready;
    assign is_last  = (r_p == r_s - 1'b1);

    // Next state and strobes
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        emit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_iter == IW'(SAMPLE_W - 1)) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX:   n_state = ST_MUL;
            ST_MUL:   n_state = ST_RECIP;
            ST_RECIP: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = is_last ? ST_IDLE : ST_MUL;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Step engine datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_v    <= i_q_pair.prev;
                r_neg  <= (i_q_pair.cur < i_q_pair.prev);
                r_mag  <= (i_q_pair.cur < i_q_pair.prev) ?
                          i_q_pair.prev - i_q_pair.cur : i_q_pair.cur - i_q_pair.prev;
                r_s    <= s_eff;
                r_rem  <= '0;
                r_iter <= '0;
            end
            ST_DIV: begin
                r_rem  <= div_ge ? SW'(div_t - {1'b0, r_s}) : div_t[SW-1:0];
                r_mag  <= {r_mag[SAMPLE_W-2:0], div_ge};
                r_iter <= r_iter + 1'b1;
            end
            ST_FIX: begin
                // Turn magnitude quotient into a floor quotient and remainder
                if (r_neg && (r_rem != '0)) begin
                    r_dq <= -$signed({1'b0, r_mag}) - 13'sd1;
                    r_dr <= r_s - r_rem;
                end else if (r_neg) begin
                    r_dq <= -$signed({1'b0, r_mag});
                    r_dr <= '0;
                end else begin
                    r_dq <= $signed({1'b0, r_mag});
                    r_dr <= r_rem;
                end
                r_r <= '0;
                r_p <= '0;
            end
            ST_MUL: begin
                r_x <= r_v * i_wrap;
            end
            ST_RECIP: begin
                r_prod <= r_x * RECIP_K;
            end
            ST_EMIT: begin
                if (emit) begin
                    r_v <= v_sum[SAMPLE_W-1:0];
                    r_r <= carry ? SW'(rsum - {1'b0, r_s}) : rsum[SW-1:0];
                    r_p <= r_p + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_duty <= r_prod[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
            r_last <= is_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_duty  = r_duty;
    assign o_last  = r_last;

endmodule
